// ----- rtl/core/ecd_pkg.sv -----
// Shared types, constants and helpers for the 1D central-difference field block.
package ecd_pkg;

    // Fixed field widths of the streaming interface and the scaling datapath.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned NODE_W = 13;
    localparam int unsigned MAG_W  = DATA_W + 1;
    localparam int unsigned INV_W  = 32;
    localparam int unsigned HALF_W = INV_W / 2;
    localparam int unsigned PROD_W = MAG_W + HALF_W;
    localparam int unsigned SUM_W  = PROD_W + 1;

    // Largest supported grid; the cell count is clamped to it where it is used.
    localparam int unsigned MAX_CELLS = 4096;
    localparam logic [NODE_W-1:0] MIN_CELLS = 13'd2;

    // Register reset values.
    localparam logic [NODE_W-1:0] CELL_COUNT_RST = 13'd2;
    localparam logic [INV_W-1:0]  INV_CELL_RST   = 32'd65536;

    // Boundary mode codes.
    localparam logic [1:0] LEFT_FIXED    = 2'd0;
    localparam logic [1:0] LEFT_PERIODIC = 2'd1;
    localparam logic       RIGHT_FIXED   = 1'b0;

    // Register map, indexed by word address.
    typedef enum logic [1:0] {
        REG_CELL_COUNT = 2'd0,
        REG_INV_CELL   = 2'd1,
        REG_LEFT_MODE  = 2'd2,
        REG_RIGHT_MODE = 2'd3
    } t_reg_idx;

    // One pending field computation: difference magnitude and sign, scale and tags.
    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic              neg;
        logic              half;
        logic [NODE_W-1:0] node;
        logic              last;
    } t_entry;

    // Builds an entry from the difference a - b, taken exactly in 33 bits.
    function automatic t_entry make_entry(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic              half,
        input logic [NODE_W-1:0] node,
        input logic              last
    );
        logic [MAG_W-1:0] diff;
        t_entry           e;
        diff   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        e.neg  = diff[MAG_W-1];
        e.mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
        e.half = half;
        e.node = node;
        e.last = last;
        return e;
    endfunction

endpackage

// ----- rtl/core/ecd_scale.sv -----
// Scaling unit: multiplies a difference by the inverse cell size, then truncates and saturates.
module ecd_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ecd_pkg::t_entry                     i_entry,
    input  logic [ecd_pkg::INV_W-1:0]           i_inv,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ecd_pkg::DATA_W-1:0]   o_field,
    output logic [ecd_pkg::NODE_W-1:0]          o_node,
    output logic                                o_last
);

    logic                              r_b_valid;
    logic [ecd_pkg::PROD_W-1:0]        r_p_hi;
    logic [ecd_pkg::PROD_W-1:0]        r_p_lo;
    logic                              r_b_neg;
    logic                              r_b_half;
    logic [ecd_pkg::NODE_W-1:0]        r_b_node;
    logic                              r_b_last;

    logic                              r_c_valid;
    logic [ecd_pkg::DATA_W-1:0]        r_field;
    logic [ecd_pkg::NODE_W-1:0]        r_node;
    logic                              r_last;

    logic                              c_load;
    logic                              b_load;
    logic [ecd_pkg::SUM_W-1:0]         sum;
    logic [ecd_pkg::SUM_W-1:0]         quot;
    logic [ecd_pkg::DATA_W-1:0]        n_field;

    // Each stage advances when the one after it is empty or moving.
    assign c_load  = !r_c_valid || i_ready;
    assign b_load  = !r_b_valid || c_load;
    assign o_ready = b_load;

    // Product stage: two 33x16 partial products against the upper and lower halves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load && i_valid) begin
            r_p_hi   <= ecd_pkg::PROD_W'(i_entry.mag)
                        * ecd_pkg::PROD_W'(i_inv[ecd_pkg::INV_W-1:ecd_pkg::HALF_W]);
            r_p_lo   <= ecd_pkg::PROD_W'(i_entry.mag)
                        * ecd_pkg::PROD_W'(i_inv[ecd_pkg::HALF_W-1:0]);
            r_b_neg  <= i_entry.neg;
            r_b_half <= i_entry.half;
            r_b_node <= i_entry.node;
            r_b_last <= i_entry.last;
        end
    end

    // Recombine the partial products, apply the extra halving and saturate.
    always_comb begin
        sum  = ecd_pkg::SUM_W'(r_p_hi) + ecd_pkg::SUM_W'(r_p_lo >> ecd_pkg::HALF_W);
        quot = r_b_half ? (sum >> 1) : sum;
        if (r_b_neg) begin
            if (quot > ecd_pkg::SUM_W'(32'h8000_0000)) begin
                n_field = 32'h8000_0000;
            end else begin
                n_field = ~quot[ecd_pkg::DATA_W-1:0] + 32'd1;
            end
        end else begin
            if (quot > ecd_pkg::SUM_W'(32'h7FFF_FFFF)) begin
                n_field = 32'h7FFF_FFFF;
            end else begin
                n_field = quot[ecd_pkg::DATA_W-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_load) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load && r_b_valid) begin
            r_field <= n_field;
            r_node  <= r_b_node;
            r_last  <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_field = r_field;
    assign o_node  = r_node;
    assign o_last  = r_last;

endmodule

// ----- rtl/core/efield_central_difference.sv -----
// Top level of the streaming 1D central-difference electric field block.

// The block takes one potential sample per cycle in node order, 0 to cell_count,
// unless held off, and returns field values tagged with their node; a result passes
// the entry, product and output registers after the sample that completes it.
// Interior samples produce one result each; the stream runs at one sample per clock
// while the result channel accepts. The final node of a pass produces up to three
// results (central field, periodic wrap at node 0, right boundary); as the one scaling
// unit issues a single result per cycle, the input is held off there. Configuration
// must be written through the APB port while the stream is idle; nothing enforces it.
module efield_central_difference (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ecd_pkg::DATA_W-1:0]   i_potential,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ecd_pkg::DATA_W-1:0]   o_field,
    output logic [ecd_pkg::NODE_W-1:0]          o_node,
    output logic                                o_last,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Configuration registers
    logic [ecd_pkg::NODE_W-1:0]   r_cell_count;
    logic [ecd_pkg::INV_W-1:0]    r_inv_cell;
    logic [1:0]                   r_left_mode;
    logic                         r_right_mode;

    // Grid walk state
    logic [ecd_pkg::NODE_W-1:0]   r_node_cnt;
    logic [ecd_pkg::DATA_W-1:0]   r_prev;
    logic [ecd_pkg::DATA_W-1:0]   r_earlier;
    logic [ecd_pkg::DATA_W-1:0]   r_second;

    // Entry stage and the queue of extra results of the final node
    logic                         r_a_valid;
    ecd_pkg::t_entry              r_a_entry;
    ecd_pkg::t_entry              r_pend [2];
    logic [1:0]                   r_pend_cnt;

    logic                         cfg_wr;
    ecd_pkg::t_reg_idx            cfg_idx;
    logic [ecd_pkg::NODE_W-1:0]   cells;
    logic                         at_final;
    logic                         a_load;
    logic                         accept;
    logic                         scale_ready;
    logic                         n_first_vld;
    ecd_pkg::t_entry              n_first;
    ecd_pkg::t_entry              n_extra0;
    ecd_pkg::t_entry              n_extra1;
    logic [1:0]                   n_extra_cnt;
    ecd_pkg::t_entry              wrap_e;
    ecd_pkg::t_entry              copy_e;
    ecd_pkg::t_entry              right_e;

    // Register file: writes complete in the access phase, reads are immediate.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = ecd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= ecd_pkg::CELL_COUNT_RST;
            r_inv_cell   <= ecd_pkg::INV_CELL_RST;
            r_left_mode  <= ecd_pkg::LEFT_FIXED;
            r_right_mode <= ecd_pkg::RIGHT_FIXED;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ecd_pkg::REG_CELL_COUNT: r_cell_count <= pwdata[ecd_pkg::NODE_W-1:0];
                ecd_pkg::REG_INV_CELL:   r_inv_cell   <= pwdata;
                ecd_pkg::REG_LEFT_MODE:  r_left_mode  <= pwdata[1:0];
                ecd_pkg::REG_RIGHT_MODE: r_right_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ecd_pkg::REG_CELL_COUNT: prdata = 32'(r_cell_count);
            ecd_pkg::REG_INV_CELL:   prdata = r_inv_cell;
            ecd_pkg::REG_LEFT_MODE:  prdata = 32'(r_left_mode);
            ecd_pkg::REG_RIGHT_MODE: prdata = 32'(r_right_mode);
            default:                 prdata = 32'd0;
        endcase
    end

    // Cell count clamped to the supported range.
    always_comb begin
        if (r_cell_count < ecd_pkg::MIN_CELLS) begin
            cells = ecd_pkg::MIN_CELLS;
        end else if (r_cell_count > ecd_pkg::NODE_W'(ecd_pkg::MAX_CELLS)) begin
            cells = ecd_pkg::NODE_W'(ecd_pkg::MAX_CELLS);
        end else begin
            cells = r_cell_count;
        end
    end

    assign at_final = (r_node_cnt >= cells);

    // Handshake: the entry stage takes a new sample only when no extras are queued.
    assign a_load  = !r_a_valid || scale_ready;
    assign o_ready = a_load && (r_pend_cnt == 2'd0);
    assign accept  = i_valid && o_ready;

    // Work out the results that the arriving sample completes.
    always_comb begin
        wrap_e  = ecd_pkg::make_entry(r_prev, r_second, 1'b1, '0, 1'b0);
        copy_e  = ecd_pkg::make_entry(r_prev, r_second, 1'b1, cells, 1'b1);
        right_e = ecd_pkg::make_entry(r_prev, i_potential, 1'b0, cells, 1'b1);

        n_first_vld = 1'b0;
        n_first     = ecd_pkg::make_entry(r_earlier, i_potential, 1'b1,
                                          r_node_cnt - ecd_pkg::NODE_W'(1), 1'b0);
        n_extra0    = wrap_e;
        n_extra1    = right_e;
        n_extra_cnt = 2'd0;

        priority if (r_node_cnt == '0) begin
            n_first_vld = 1'b0;
        end else if (r_node_cnt == ecd_pkg::NODE_W'(1)) begin
            // Left boundary: first-order difference only in fixed mode.
            n_first_vld = (r_left_mode == ecd_pkg::LEFT_FIXED);
            n_first     = ecd_pkg::make_entry(r_prev, i_potential, 1'b0, '0, 1'b0);
        end else if (!at_final) begin
            n_first_vld = 1'b1;
        end else begin
            // Final node: central field first, then the wrap and right boundary results the modes call for.
            n_first_vld = 1'b1;
            n_first.node = cells - ecd_pkg::NODE_W'(1);
            if (r_left_mode == ecd_pkg::LEFT_PERIODIC) begin
                n_extra_cnt = 2'd2;
                n_extra0    = wrap_e;
                n_extra1    = (r_right_mode == ecd_pkg::RIGHT_FIXED) ? right_e : copy_e;
            end else if (r_right_mode == ecd_pkg::RIGHT_FIXED) begin
                n_extra_cnt = 2'd1;
                n_extra0    = right_e;
            end else begin
                n_first.last = 1'b1;
            end
        end
    end

    // Grid walk: three-sample window and the node counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= '0;
            r_prev     <= '0;
            r_earlier  <= '0;
            r_second   <= '0;
        end else if (accept) begin
            r_node_cnt <= at_final ? '0 : r_node_cnt + ecd_pkg::NODE_W'(1);
            r_earlier  <= r_prev;
            r_prev     <= i_potential;
            if (r_node_cnt == ecd_pkg::NODE_W'(1)) begin
                r_second <= i_potential;
            end
        end
    end

    // Entry stage control: queued extras go first, then the next sample's result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_pend_cnt <= 2'd0;
        end else if (a_load) begin
            if (r_pend_cnt != 2'd0) begin
                r_a_valid  <= 1'b1;
                r_pend_cnt <= r_pend_cnt - 2'd1;
            end else if (accept) begin
                r_a_valid  <= n_first_vld;
                r_pend_cnt <= n_extra_cnt;
            end else begin
                r_a_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            if (r_pend_cnt != 2'd0) begin
                r_a_entry <= r_pend[0];
                r_pend[0] <= r_pend[1];
            end else if (accept) begin
                r_a_entry <= n_first;
                r_pend[0] <= n_extra0;
                r_pend[1] <= n_extra1;
            end
        end
    end

    // Multiply, truncate and saturate, ending in the output register.
    ecd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .o_ready (scale_ready),
        .i_entry (r_a_entry),
        .i_inv   (r_inv_cell),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_field (o_field),
        .o_node  (o_node),
        .o_last  (o_last)
    );

    // The extras queue holds at most the two trailing results of a final node.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= 2'd2)
        else $error("extras queue overfilled");

    // No sample transfer while extras are still queued.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt != 2'd0) |-> !o_ready)
        else $error("sample taken while extras pending");

    // The node counter never runs past the largest grid.
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_cnt <= ecd_pkg::NODE_W'(ecd_pkg::MAX_CELLS))
        else $error("node counter out of range");

    // A transfer at the final node restarts the pass.
    a_pass_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && at_final) |=> (r_node_cnt == '0))
        else $error("pass did not restart after final node");

endmodule
